FILE: rtl/clwi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clwi_pkg
// Shared types and constants of the circular list block: command codes,
// status codes, controller states and the cell operation code.
// ----------------------------------------------------------------------------
package clwi_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 4;
  localparam int POS_W  = 16;
  localparam int STEP_W = 16;
  localparam int STAT_W = 2;

  // command codes
  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT  = 4'd0,
    K_PUSH_BACK   = 4'd1,
    K_INSERT_AT   = 4'd2,
    K_POP_FRONT   = 4'd3,
    K_POP_BACK    = 4'd4,
    K_DELETE_AT   = 4'd5,
    K_READ_AT     = 4'd6,
    K_ROTATE_LEFT = 4'd7,
    K_ROTATE_RIGHT = 4'd8
  } kind_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_ROT,
    S_DONE
  } state_t;

  // operation applied to every cell of the chain in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

endpackage

FILE: rtl/clwi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clwi_if
// Valid/ready channels of the circular list: command in, result out.
// ----------------------------------------------------------------------------
interface clwi_in_if;
  logic                               valid;
  logic                               ready;
  logic [clwi_pkg::KIND_W-1:0]        kind;
  logic signed [clwi_pkg::DATA_W-1:0] value;
  logic signed [clwi_pkg::POS_W-1:0]  position;
  logic [clwi_pkg::STEP_W-1:0]        step;

  modport source (output valid, kind, value, position, step, input ready);
  modport sink (input valid, kind, value, position, step, output ready);
endinterface

interface clwi_out_if #(parameter int CAPACITY = 16);
  localparam int LEN_W = $clog2(CAPACITY + 1);

  logic                               valid;
  logic                               ready;
  logic signed [clwi_pkg::DATA_W-1:0] read_value;
  logic [LEN_W-1:0]                   length;
  logic                               list_empty;
  logic [clwi_pkg::STAT_W-1:0]        status;

  modport source (output valid, read_value, length, list_empty, status, input ready);
  modport sink (input valid, read_value, length, list_empty, status, output ready);
endinterface

FILE: rtl/circular_list_with_wrapped_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_with_wrapped_index
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Each command returns one result carrying the read value, the count, an
// empty flag and a status. Push and pop at either end, and any command that
// is rejected as full or empty, go from the start state straight to the
// done state. Insert, delete and read at a position, and rotate, first
// reduce the position or step modulo the count in a bit-serial remainder
// unit; a rotation then shifts the cell chain circularly one place per
// cycle, for an amount below the count. Insert and delete move every cell
// in the same cycle. A new command is taken once the previous one has been
// handed to the result register.
// ----------------------------------------------------------------------------
module circular_list_with_wrapped_index #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  clwi_in_if.sink      in_ch,
  clwi_out_if.source   out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // state
  clwi_pkg::state_t                   state, state_next;
  logic [CW-1:0]                      cnt, cnt_next;
  logic [CW-1:0]                      rot, rot_next;
  logic signed [clwi_pkg::DATA_W-1:0] res_rd, res_rd_next;
  clwi_pkg::status_t                  res_status, res_status_next;

  // latched command
  logic [clwi_pkg::KIND_W-1:0]        kind_q;
  logic signed [clwi_pkg::DATA_W-1:0] value_q;
  logic                               pneg_q;
  logic [clwi_pkg::POS_W-1:0]         mag_q;

  // result register
  logic                               out_valid;
  logic signed [clwi_pkg::DATA_W-1:0] out_rd;
  logic [CW-1:0]                      out_len;
  clwi_pkg::status_t                  out_status;
  logic                               out_load;

  // chain control
  clwi_pkg::cell_op_t                 cell_op;
  logic [CW-1:0]                      cell_idx;
  logic signed [clwi_pkg::DATA_W-1:0] cell_data [CAPACITY];

  // remainder unit
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [CW-1:0] div_rem;

  // wrapped positions
  logic [CW-1:0] acc_idx;
  logic [CW-1:0] ins_idx;
  logic [CW-1:0] rot_amt;

  logic in_xfer;
  logic is_rot;

  assign in_ch.ready = (state == clwi_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign is_rot      = (in_ch.kind == clwi_pkg::K_ROTATE_LEFT) ||
                       (in_ch.kind == clwi_pkg::K_ROTATE_RIGHT);

  // command capture; magnitude to reduce is the step or |position|
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_q  <= in_ch.kind;
      value_q <= in_ch.value;
      pneg_q  <= in_ch.position[clwi_pkg::POS_W-1];
      if (is_rot) begin
        mag_q <= in_ch.step;
      end else if (in_ch.position[clwi_pkg::POS_W-1]) begin
        mag_q <= (~in_ch.position) + 1'b1;
      end else begin
        mag_q <= in_ch.position;
      end
    end
  end

  // position wrap from the remainder
  always_comb begin
    if (pneg_q) begin
      acc_idx = (div_rem == '0) ? '0 : cnt - div_rem;
      ins_idx = (div_rem == '0) ? CW'(1) : cnt - div_rem + 1'b1;
    end else begin
      acc_idx = div_rem;
      if (mag_q <= clwi_pkg::POS_W'(cnt)) begin
        ins_idx = CW'(mag_q);
      end else begin
        ins_idx = (div_rem == '0) ? cnt : div_rem;
      end
    end
    if (kind_q == clwi_pkg::K_ROTATE_RIGHT) begin
      rot_amt = (div_rem == '0) ? '0 : cnt - div_rem;
    end else begin
      rot_amt = div_rem;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clwi_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rot        <= rot_next;
    res_rd     <= res_rd_next;
    res_status <= res_status_next;
  end

  // next state and chain control
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    rot_next        = rot;
    res_rd_next     = res_rd;
    res_status_next = res_status;
    cell_op         = clwi_pkg::CELL_HOLD;
    cell_idx        = '0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    case (state)
      clwi_pkg::S_IDLE: begin
        res_rd_next     = '0;
        res_status_next = clwi_pkg::ST_DONE;
        if (in_xfer) begin
          state_next = clwi_pkg::S_START;
        end
      end
      clwi_pkg::S_START: begin
        state_next = clwi_pkg::S_DONE;
        case (clwi_pkg::kind_t'(kind_q))
          clwi_pkg::K_PUSH_FRONT, clwi_pkg::K_PUSH_BACK, clwi_pkg::K_INSERT_AT: begin
            if (cnt == CAP) begin
              res_status_next = clwi_pkg::ST_FULL;
            end else if (kind_q == clwi_pkg::K_PUSH_BACK) begin
              cell_op  = clwi_pkg::CELL_INSERT;
              cell_idx = cnt;
              cnt_next = cnt + 1'b1;
            end else if (kind_q == clwi_pkg::K_INSERT_AT && cnt != '0) begin
              div_start  = 1'b1;
              state_next = clwi_pkg::S_DIV;
            end else begin
              cell_op  = clwi_pkg::CELL_INSERT;
              cell_idx = '0;
              cnt_next = cnt + 1'b1;
            end
          end
          clwi_pkg::K_POP_FRONT, clwi_pkg::K_POP_BACK, clwi_pkg::K_DELETE_AT,
          clwi_pkg::K_READ_AT, clwi_pkg::K_ROTATE_LEFT, clwi_pkg::K_ROTATE_RIGHT: begin
            if (cnt == '0) begin
              res_status_next = clwi_pkg::ST_EMPTY;
            end else if (kind_q == clwi_pkg::K_POP_FRONT) begin
              cell_op  = clwi_pkg::CELL_DELETE;
              cell_idx = '0;
              cnt_next = cnt - 1'b1;
            end else if (kind_q == clwi_pkg::K_POP_BACK) begin
              cell_op  = clwi_pkg::CELL_DELETE;
              cell_idx = cnt - 1'b1;
              cnt_next = cnt - 1'b1;
            end else begin
              div_start  = 1'b1;
              state_next = clwi_pkg::S_DIV;
            end
          end
          default: begin
            res_status_next = clwi_pkg::ST_DONE;
          end
        endcase
      end
      clwi_pkg::S_DIV: begin
        if (div_done) begin
          state_next = clwi_pkg::S_DONE;
          case (clwi_pkg::kind_t'(kind_q))
            clwi_pkg::K_INSERT_AT: begin
              cell_op  = clwi_pkg::CELL_INSERT;
              cell_idx = ins_idx;
              cnt_next = cnt + 1'b1;
            end
            clwi_pkg::K_DELETE_AT: begin
              cell_op  = clwi_pkg::CELL_DELETE;
              cell_idx = acc_idx;
              cnt_next = cnt - 1'b1;
            end
            clwi_pkg::K_READ_AT: begin
              res_rd_next = cell_data[acc_idx[IW-1:0]];
            end
            clwi_pkg::K_ROTATE_LEFT, clwi_pkg::K_ROTATE_RIGHT: begin
              rot_next = rot_amt;
              if (rot_amt != '0) begin
                state_next = clwi_pkg::S_ROT;
              end
            end
            default: begin
              state_next = clwi_pkg::S_DONE;
            end
          endcase
        end
      end
      clwi_pkg::S_ROT: begin
        cell_op  = clwi_pkg::CELL_ROTATE;
        rot_next = rot - 1'b1;
        if (rot == CW'(1)) begin
          state_next = clwi_pkg::S_DONE;
        end
      end
      clwi_pkg::S_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = clwi_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = clwi_pkg::S_IDLE;
      end
    endcase
  end

  // result register, frees the controller while the result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd     <= res_rd;
      out_len    <= cnt;
      out_status <= res_status;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_value = out_rd;
  assign out_ch.length     = out_len;
  assign out_ch.list_empty = (out_len == '0);
  assign out_ch.status     = out_status;

  // remainder unit
  clwi_div #(
    .NW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_q),
    .divisor  (cnt),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  // chain of element cells, position 0 first
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [clwi_pkg::DATA_W-1:0] left_d;
    logic signed [clwi_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = value_q;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    clwi_cell #(
      .INDEX(i),
      .CW   (CW)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .idx        (cell_idx),
      .count      (cnt),
      .value      (value_q),
      .left_data  (left_d),
      .right_data (right_d),
      .first_data (cell_data[0]),
      .data       (cell_data[i])
    );
  end

  // count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP)
    else $error("element count above capacity");

  // a rotation runs only for a nonzero amount shorter than the list
  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    (state == clwi_pkg::S_ROT) |-> (rot != '0 && rot < cnt))
    else $error("rotation amount out of range");

  // the remainder unit is working whenever the controller waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == clwi_pkg::S_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle remainder unit");

  // a held result blocks the controller from overwriting it
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == clwi_pkg::S_DONE && out_valid && !out_ch.ready)
      |=> (state == clwi_pkg::S_DONE))
    else $error("result register overwritten");

  // no new command while a reduction is in flight
  a_xfer_quiet: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> !div_busy)
    else $error("command taken during reduction");

endmodule

FILE: rtl/clwi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clwi_cell
// One cell of the element chain. Holds the element at a fixed list position
// and takes its neighbor's value on insert, delete and rotate.
// ----------------------------------------------------------------------------
module clwi_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                               clk,
  input  clwi_pkg::cell_op_t                 op,
  input  logic [CW-1:0]                      idx,
  input  logic [CW-1:0]                      count,
  input  logic signed [clwi_pkg::DATA_W-1:0] value,
  input  logic signed [clwi_pkg::DATA_W-1:0] left_data,
  input  logic signed [clwi_pkg::DATA_W-1:0] right_data,
  input  logic signed [clwi_pkg::DATA_W-1:0] first_data,
  output logic signed [clwi_pkg::DATA_W-1:0] data
);

  localparam logic [CW-1:0] MY_IDX  = CW'(INDEX);
  localparam logic [CW-1:0] MY_NEXT = CW'(INDEX + 1);

  // element register, moves with its neighbors
  always_ff @(posedge clk) begin
    case (op)
      clwi_pkg::CELL_INSERT: begin
        if (MY_IDX == idx) begin
          data <= value;
        end else if (MY_IDX > idx) begin
          data <= left_data;
        end
      end
      clwi_pkg::CELL_DELETE: begin
        if (MY_IDX >= idx) begin
          data <= right_data;
        end
      end
      clwi_pkg::CELL_ROTATE: begin
        if (MY_NEXT == count) begin
          data <= first_data;
        end else if (MY_NEXT < count) begin
          data <= right_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

FILE: rtl/clwi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clwi_div
// Restoring remainder unit: reduces a 16-bit magnitude modulo the element
// count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module clwi_div #(
  parameter int NW = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [clwi_pkg::POS_W-1:0] dividend,
  input  logic [NW-1:0]              divisor,
  output logic                       busy,
  output logic                       done,
  output logic [NW-1:0]              rem
);

  localparam int DW = clwi_pkg::POS_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    shreg;
  logic [CNT_W-1:0] steps;
  logic [NW:0]      trial;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, shreg[DW-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(DW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: one compare and subtract per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= NW'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[NW-1:0];
      end
    end
  end

endmodule

FILE: bench/circular_list_with_wrapped_index_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_with_wrapped_index_tb
// Self-checking bench for the circular list. Commands go in on the input
// channel with random gaps, and results are taken with random stalls. Every
// accepted command updates a queue-based copy of the list, which yields the
// expected result. The checker compares each result with the oldest expected
// one. Directed commands cover the empty list, extreme fields and the wrap
// rules. Random phases then drive the list between empty and full.
// ----------------------------------------------------------------------------
module circular_list_with_wrapped_index_tb;
  import clwi_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int LEN_W         = $clog2(CAPACITY + 1);
  localparam int KIND_TOP      = (1 << KIND_W) - 1;
  localparam int KIND_UNUSED   = int'(K_ROTATE_RIGHT) + 1;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int SHOWN_ERRORS  = 10;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic [STEP_W-1:0]        step_t;

  localparam word_t VAL_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t VAL_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam pos_t  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam pos_t  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam step_t STEP_MAX = '1;

  typedef struct packed {
    word_t             read_value;
    logic [LEN_W-1:0]  length;
    logic              list_empty;
    status_t           status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  clwi_in_if in_ch();
  clwi_out_if #(.CAPACITY(CAPACITY)) out_ch();

  circular_list_with_wrapped_index #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // list contents in order from the front, and results still to come
  word_t        held_values[$];
  list_result_t pending_results[$];

  int  cycle_count   = 0;
  int  error_count   = 0;
  int  commands_sent = 0;
  int  results_seen  = 0;
  int  full_hits     = 0;
  int  empty_hits    = 0;
  int  stall_left    = 0;
  bit  steady        = 1'b0;

  list_result_t got_result;
  list_result_t want_result;

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // idle length: mostly short, a few long
  function automatic int random_gap();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic word_t random_value();
    case ($urandom_range(19))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic pos_t random_position();
    int r;
    r = $urandom_range(99);
    if (r < 50) return pos_t'(int'($urandom_range(40)) - 20);
    if (r < 55) return POS_MIN;
    if (r < 60) return POS_MAX;
    return pos_t'($urandom);
  endfunction

  // delete/read position wrapped by the count
  function automatic int wrap_access(pos_t position, int n);
    int k;
    if (position < 0) begin
      k = -int'(position);
      return (n - (k % n)) % n;
    end
    return int'(position) % n;
  endfunction

  // apply one command to the list copy and return its result
  function automatic list_result_t predict_command(logic [KIND_W-1:0] kind,
      word_t value, pos_t position, step_t step);
    list_result_t res;
    int n;
    int k;
    int idx;
    int shift;
    word_t moved;
    n = held_values.size();
    res.read_value = '0;
    res.status = ST_DONE;
    case (kind)
      K_PUSH_FRONT, K_PUSH_BACK, K_INSERT_AT: begin
        if (n >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (kind == K_PUSH_FRONT || (kind == K_INSERT_AT && n == 0)) begin
          held_values.insert(0, value);
        end else if (kind == K_PUSH_BACK) begin
          held_values.insert(n, value);
        end else begin
          // insert position: negative counts from the back, large wraps
          if (position < 0) begin
            k = -int'(position);
            if ((k - 1) % n == 0) idx = n;
            else idx = n - (k % n) + 1;
          end else begin
            idx = int'(position);
            if (idx > n) idx = (idx % n == 0) ? n : idx % n;
          end
          if (idx > n) idx = idx % n;
          held_values.insert(idx, value);
        end
      end
      K_POP_FRONT, K_POP_BACK, K_DELETE_AT, K_READ_AT, K_ROTATE_LEFT,
      K_ROTATE_RIGHT: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          case (kind)
            K_POP_FRONT: held_values.delete(0);
            K_POP_BACK:  held_values.delete(n - 1);
            K_DELETE_AT: held_values.delete(wrap_access(position, n));
            K_READ_AT:   res.read_value = held_values[wrap_access(position, n)];
            default: begin
              // right rotation is a left rotation by the complement
              shift = int'(step) % n;
              if (kind == K_ROTATE_RIGHT) shift = (n - shift) % n;
              repeat (shift) begin
                moved = held_values[0];
                held_values.delete(0);
                held_values.insert(held_values.size(), moved);
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    if (res.status == ST_FULL) full_hits++;
    if (res.status == ST_EMPTY) empty_hits++;
    res.length = LEN_W'(held_values.size());
    res.list_empty = (held_values.size() == 0);
    return res;
  endfunction

  // one command transfer; valid stays high when no gap follows
  task automatic send_command(input logic [KIND_W-1:0] kind, input word_t value,
                              input pos_t position, input step_t step);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 30) gap = random_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.value    <= value;
    in_ch.position <= position;
    in_ch.step     <= step;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(),
                           predict_command(kind, value, position, step));
    commands_sent++;
  endtask

  // result check and sink stalls
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got_result = '{out_ch.read_value, out_ch.length, out_ch.list_empty,
                     status_t'(out_ch.status)};
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS)
          $display("unexpected result: value %0d length %0d empty %0b status %0d",
                   got_result.read_value, got_result.length, got_result.list_empty,
                   got_result.status);
      end else begin
        want_result = pending_results[0];
        pending_results.delete(0);
        if (got_result !== want_result) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("result %0d mismatch: expected value %0d length %0d empty %0b status %0d",
                     results_seen, want_result.read_value, want_result.length,
                     want_result.list_empty, want_result.status);
            $display("  got value %0d length %0d empty %0b status %0d",
                     got_result.read_value, got_result.length, got_result.list_empty,
                     got_result.status);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!rst && !steady && $urandom_range(99) < 15) begin
      stall_left = random_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // commands on an empty list, and unused kinds
  task automatic test_empty_list();
    send_command(K_POP_FRONT, '0, '0, '0);
    send_command(K_POP_BACK, '0, '0, '0);
    send_command(K_DELETE_AT, '0, -16'sd1, '0);
    send_command(K_READ_AT, '0, '0, '0);
    send_command(K_ROTATE_LEFT, '0, '0, STEP_MAX);
    send_command(K_ROTATE_RIGHT, '0, '0, 16'd1);
    send_command(KIND_W'(KIND_UNUSED), '1, '1, STEP_MAX);
    send_command(KIND_W'(KIND_TOP), '1, POS_MIN, STEP_MAX);
  endtask

  // extreme fields and the position wrap rules
  task automatic test_wrap_rules();
    // insert on an empty list ignores the position
    send_command(K_INSERT_AT, VAL_MAX, POS_MIN, '0);
    send_command(K_PUSH_FRONT, VAL_MIN, '0, '0);
    send_command(K_PUSH_BACK, '0, '0, '0);
    send_command(K_PUSH_BACK, '1, '0, '0);
    send_command(K_READ_AT, '0, POS_MAX, '0);
    send_command(K_READ_AT, '0, POS_MIN, '0);
    send_command(K_READ_AT, '0, -16'sd1, '0);
    // past the end, with and without a remainder
    send_command(K_INSERT_AT, 32'sd11, 16'sd9, '0);
    send_command(K_INSERT_AT, 32'sd22, 16'sd10, '0);
    // minus one appends; minus the count lands on position one
    send_command(K_INSERT_AT, 32'sd33, -16'sd1, '0);
    send_command(K_INSERT_AT, 32'sd44, -16'sd7, '0);
    send_command(K_DELETE_AT, '0, POS_MIN, '0);
    send_command(K_DELETE_AT, '0, POS_MAX, '0);
    send_command(K_ROTATE_LEFT, '0, '0, '0);
    send_command(K_ROTATE_LEFT, '0, '0, STEP_MAX);
    send_command(K_ROTATE_RIGHT, '0, '0, 16'd3);
    send_command(K_READ_AT, '0, '0, '0);
  endtask

  // fill to capacity, get pushes rejected, then empty the list
  task automatic test_fill_and_drain();
    while (held_values.size() < CAPACITY)
      send_command(KIND_W'($urandom_range(int'(K_INSERT_AT), int'(K_PUSH_FRONT))),
                   random_value(), random_position(), '0);
    send_command(K_PUSH_FRONT, random_value(), '0, '0);
    send_command(K_PUSH_BACK, random_value(), '0, '0);
    send_command(K_INSERT_AT, random_value(), random_position(), '0);
    send_command(K_READ_AT, '0, POS_MIN, '0);
    send_command(K_ROTATE_RIGHT, '0, '0, STEP_MAX);
    send_command(K_READ_AT, '0, -16'sd1, '0);
    while (held_values.size() > 0)
      send_command(KIND_W'($urandom_range(int'(K_DELETE_AT), int'(K_POP_FRONT))),
                   '0, random_position(), '0);
  endtask

  // random commands; grow_pct sets the share of pushes and inserts
  task automatic run_random_commands(input int count, input int grow_pct);
    int r;
    logic [KIND_W-1:0] kind;
    step_t step;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 3) kind = KIND_W'($urandom_range(KIND_TOP, KIND_UNUSED));
      else if (r < 3 + grow_pct)
        kind = KIND_W'($urandom_range(int'(K_INSERT_AT), int'(K_PUSH_FRONT)));
      else kind = KIND_W'($urandom_range(int'(K_ROTATE_RIGHT), int'(K_POP_FRONT)));
      case ($urandom_range(9))
        0: step = '0;
        1: step = STEP_MAX;
        2, 3, 4: step = step_t'($urandom_range(40));
        default: step = step_t'($urandom);
      endcase
      send_command(kind, random_value(), random_position(), step);
    end
  endtask

  // no gaps and no stalls
  task automatic test_back_to_back();
    steady = 1'b1;
    run_random_commands(150, 50);
    steady = 1'b0;
  endtask

  // alternate growing, shrinking and balanced traffic
  task automatic test_random_mix();
    repeat (5) begin
      run_random_commands(80, 65);
      run_random_commands(80, 25);
      run_random_commands(60, 45);
    end
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= '0;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    in_ch.step     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_wrap_rules();
    test_fill_and_drain();
    test_back_to_back();
    test_random_mix();
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d commands and checked %0d results in %0d cycles",
             commands_sent, results_seen, cycle_count);
    $display("pushes rejected on a full list: %0d, commands on an empty list: %0d",
             full_hits, empty_hits);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
